### design/slbm_pkg.sv
// Shared types, constants and tables of the log-band bar mapper.
package slbm_pkg;

  // Frame and band geometry
  localparam int unsigned BINS       = 32;
  localparam int unsigned BAND_COUNT = 20;
  localparam int unsigned FIRST_BIN  = 2;

  localparam int unsigned BIN_W   = $clog2(BINS);
  localparam int unsigned BAND_W  = $clog2(BAND_COUNT + 1);
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned AVG_W   = 15;

  // Configuration field widths
  localparam int unsigned NF_W    = 10;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned FS_W    = 16;
  localparam int unsigned BMAX_W  = 5;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Result field widths and character codes
  localparam int unsigned HEIGHT_W = 5;
  localparam int unsigned CODE_W   = 6;
  localparam logic [CODE_W-1:0] BLANK_CODE = 6'd32;
  localparam logic [CODE_W-1:0] FULL_CODE  = 6'd7;

  // Depth of the job queue between front and back
  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // floor((BINS-1) * (25/32)^(BAND_COUNT-1-k)); band k ends on the first bin above it
  localparam logic [BIN_W-1:0] EDGE_FLOOR [BAND_COUNT] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2,
    5'd3, 5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd14, 5'd18, 5'd24, 5'd31
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_FLOOR = 2'd0,
    CFG_GAIN        = 2'd1,
    CFG_FULL_SCALE  = 2'd2,
    CFG_BAR_MAX     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [NF_W-1:0]   noise_floor;
    logic [GAIN_W-1:0] gain;
    logic [FS_W-1:0]   full_scale;
    logic [BMAX_W-1:0] bar_max;
  } cfg_t;

  // One closed band, handed from front to back
  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               last;
  } job_t;

endpackage

### design/slbm_front.sv
// Front end: counts bins, accumulates bands and issues a job per closed band.
module slbm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [slbm_pkg::MAG_W-1:0] magnitude_i,
  output logic                       job_push_o,
  output slbm_pkg::job_t             job_o
);
  import slbm_pkg::*;

  logic [BIN_W-1:0]   bin_q, bin_d;
  logic [BAND_W-1:0]  band_q, band_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic               summing, last, band_open, close_band, tail_band;
  logic [BIN_W-1:0]   edge_bin;
  logic [SUM_W-1:0]   sum_new;
  logic [COUNT_W-1:0] count_new;

  // Classify the incoming bin
  always_comb begin
    summing   = bin_q >= BIN_W'(FIRST_BIN);
    last      = bin_q == BIN_W'(BINS - 1);
    band_open = band_q < BAND_W'(BAND_COUNT);
    edge_bin  = band_open ? EDGE_FLOOR[band_q] : '0;
    sum_new   = summing ? sum_q + SUM_W'(magnitude_i) : sum_q;
    count_new = summing ? count_q + COUNT_W'(1) : count_q;
    close_band = summing && band_open && (bin_q > edge_bin);
    tail_band  = last && !close_band && band_open && (count_new != '0);
  end

  // Advance the counters
  always_comb begin
    bin_d   = bin_q;
    band_d  = band_q;
    sum_d   = sum_q;
    count_d = count_q;
    if (accept_i) begin
      if (last) begin
        bin_d   = '0;
        band_d  = '0;
        sum_d   = '0;
        count_d = '0;
      end else begin
        bin_d = bin_q + BIN_W'(1);
        if (close_band) begin
          band_d  = band_q + BAND_W'(1);
          sum_d   = '0;
          count_d = '0;
        end else begin
          sum_d   = sum_new;
          count_d = count_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q   <= '0;
      band_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      bin_q   <= bin_d;
      band_q  <= band_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // Hand the closed band to the back end
  assign job_push_o  = accept_i && (close_band || tail_band);
  assign job_o.band  = band_q;
  assign job_o.sum   = sum_new;
  assign job_o.count = count_new;
  assign job_o.last  = last;

endmodule

### design/slbm_job_fifo.sv
// Short job queue that decouples the front end from the back end.
module slbm_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slbm_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output slbm_pkg::job_t data_o
);
  import slbm_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_q, rd_q;
  logic [JOB_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == JOB_CNT_W'(JOB_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance the pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + JOB_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - JOB_CNT_W'(1);
      end
    end
  end

endmodule

### design/slbm_back.sv
// Back end: averages a band, applies floor, gain and clamp, scales to a bar.
module slbm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slbm_pkg::cfg_t                cfg_i,
  input  logic                          job_valid_i,
  input  slbm_pkg::job_t                job_i,
  output logic                          job_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [slbm_pkg::BAND_W-1:0]   band_index_o,
  output logic [slbm_pkg::HEIGHT_W-1:0] band_height_o,
  output logic [slbm_pkg::CODE_W-1:0]   top_row_code_o,
  output logic [slbm_pkg::CODE_W-1:0]   middle_row_code_o,
  output logic [slbm_pkg::CODE_W-1:0]   bottom_row_code_o,
  output logic                          frame_end_o
);
  import slbm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_CLAMP = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_QUOT  = 6'b010000,
    ST_LOAD  = 6'b100000
  } state_e;

  localparam int unsigned PROD_W  = AVG_W + GAIN_W;
  localparam int unsigned SCALE_W = FS_W + BMAX_W;
  localparam int unsigned ITER_W  = $clog2(SUM_W);

  state_e               state_q, state_d;
  logic [ITER_W-1:0]    iter_q, iter_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [COUNT_W-1:0]   div_q, div_d;
  logic [BAND_W-1:0]    band_q, band_d;
  logic                 last_q, last_d;
  logic [FS_W-1:0]      aux_q, aux_d;
  logic [FS_W-1:0]      srem_q, srem_d;
  logic [BMAX_W-1:0]    sq_q, sq_d;
  logic                 out_valid_q, out_valid_d;
  logic [BAND_W-1:0]    out_band_q, out_band_d;
  logic [HEIGHT_W-1:0]  out_height_q, out_height_d;
  logic                 out_last_q, out_last_d;

  logic [COUNT_W:0]     rem_sh;
  logic [COUNT_W:0]     rem_sub;
  logic [AVG_W-1:0]     avg;
  logic [AVG_W-1:0]     diff;
  logic [PROD_W-1:0]    prod;
  logic [SCALE_W-1:0]   scaled;
  logic [FS_W:0]        srem_sh;
  logic [FS_W:0]        srem_sub;
  logic [HEIGHT_W-1:0]  height;

  // Character for one LCD row of a bar
  function automatic logic [CODE_W-1:0] row_code(input logic [HEIGHT_W-1:0] h,
                                                 input logic [1:0] row);
    logic [1:0] a;
    logic [2:0] rest;
    a    = h[HEIGHT_W-1:3];
    rest = h[2:0];
    if (a == row) begin
      row_code = (rest != 3'd0) ? CODE_W'(rest - 3'd1) : BLANK_CODE;
    end else if (a > row) begin
      row_code = FULL_CODE;
    end else begin
      row_code = BLANK_CODE;
    end
  endfunction

  // Datapath pieces shared by the states
  always_comb begin
    rem_sh   = {rem_q, quo_q[SUM_W-1]};
    rem_sub  = rem_sh - {1'b0, div_q};
    avg      = quo_q[AVG_W-1:0];
    diff     = avg - AVG_W'(cfg_i.noise_floor);
    prod     = PROD_W'(diff) * PROD_W'(cfg_i.gain);
    scaled   = SCALE_W'(aux_q) * SCALE_W'(cfg_i.bar_max);
    srem_sh  = {srem_q, sq_q[BMAX_W-1]};
    srem_sub = srem_sh - {1'b0, cfg_i.full_scale};
    height   = (cfg_i.full_scale == '0) ? '0 : HEIGHT_W'(sq_q);
  end

  // Sequence one job through divide, clamp, scale and quotient
  always_comb begin
    state_d      = state_q;
    iter_d       = iter_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    div_d        = div_q;
    band_d       = band_q;
    last_d       = last_q;
    aux_d        = aux_q;
    srem_d       = srem_q;
    sq_d         = sq_q;
    out_valid_d  = out_valid_q && !pop;
    out_band_d   = out_band_q;
    out_height_d = out_height_q;
    out_last_d   = out_last_q;
    job_pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          quo_d     = job_i.sum;
          rem_d     = '0;
          div_d     = job_i.count;
          band_d    = job_i.band;
          last_d    = job_i.last;
          iter_d    = ITER_W'(SUM_W - 1);
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = rem_sub[COUNT_W-1:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[COUNT_W-1:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b0};
        end
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (avg > AVG_W'(cfg_i.noise_floor)) begin
          aux_d = (prod > PROD_W'(cfg_i.full_scale)) ? cfg_i.full_scale
                                                    : prod[FS_W-1:0];
        end else begin
          aux_d = '0;
        end
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        srem_d  = scaled[SCALE_W-1:BMAX_W];
        sq_d    = scaled[BMAX_W-1:0];
        iter_d  = ITER_W'(BMAX_W - 1);
        state_d = ST_QUOT;
      end
      ST_QUOT: begin
        if (srem_sh >= {1'b0, cfg_i.full_scale}) begin
          srem_d = srem_sub[FS_W-1:0];
          sq_d   = {sq_q[BMAX_W-2:0], 1'b1};
        end else begin
          srem_d = srem_sh[FS_W-1:0];
          sq_d   = {sq_q[BMAX_W-2:0], 1'b0};
        end
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_q || pop) begin
          out_valid_d  = 1'b1;
          out_band_d   = band_q;
          out_height_d = height;
          out_last_d   = last_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the working and result registers
  always_ff @(posedge clk_i) begin
    iter_q       <= iter_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    band_q       <= band_d;
    last_q       <= last_d;
    aux_q        <= aux_d;
    srem_q       <= srem_d;
    sq_q         <= sq_d;
    out_band_q   <= out_band_d;
    out_height_q <= out_height_d;
    out_last_q   <= out_last_d;
  end

  // Drive the result beat
  assign empty             = !out_valid_q;
  assign band_index_o      = out_band_q;
  assign band_height_o     = out_height_q;
  assign top_row_code_o    = row_code(out_height_q, 2'd2);
  assign middle_row_code_o = row_code(out_height_q, 2'd1);
  assign bottom_row_code_o = row_code(out_height_q, 2'd0);
  assign frame_end_o       = out_last_q;

endmodule

### design/spectrum_log_band_bar_mapper.sv
// Top level of the log-band bar mapper: configuration registers and the two halves.
// Bins are pushed in frame order from bin 0; bins 0 and 1 are skipped and every later
// bin is summed into the open band, which closes once the bin index passes the band's
// edge (the final partial band closes on the last bin, with frame_end set). A bin is
// taken whenever the four-entry job queue has room; each closed band then passes
// through the back end in order: load, the bit-serial average division, floor, gain
// and clamp, the bar_max product, the bit-serial height quotient and the move into
// the result register. The result register lets the back end finish the next band
// while a result waits to be popped. Write the configuration registers only while
// the block is idle.
module spectrum_log_band_bar_mapper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [slbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [slbm_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic [slbm_pkg::MAG_W-1:0]        magnitude_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [slbm_pkg::BAND_W-1:0]       band_index_o,
  output logic [slbm_pkg::HEIGHT_W-1:0]     band_height_o,
  output logic [slbm_pkg::CODE_W-1:0]       top_row_code_o,
  output logic [slbm_pkg::CODE_W-1:0]       middle_row_code_o,
  output logic [slbm_pkg::CODE_W-1:0]       bottom_row_code_o,
  output logic                              frame_end_o
);
  import slbm_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic accept;
  logic job_push, job_full, job_valid, job_pop;
  job_t job_in, job_out;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_NOISE_FLOOR: cfg_d.noise_floor = cfg_wdata_i[NF_W-1:0];
        CFG_GAIN:        cfg_d.gain        = cfg_wdata_i[GAIN_W-1:0];
        CFG_FULL_SCALE:  cfg_d.full_scale  = cfg_wdata_i[FS_W-1:0];
        CFG_BAR_MAX:     cfg_d.bar_max     = cfg_wdata_i[BMAX_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_floor <= NF_W'(3);
      cfg_q.gain        <= GAIN_W'(100);
      cfg_q.full_scale  <= FS_W'(1024);
      cfg_q.bar_max     <= BMAX_W'(24);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take a bin whenever the job queue has room
  assign full   = job_full;
  assign accept = push && !job_full;

  slbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .magnitude_i (magnitude_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  slbm_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  slbm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .job_valid_i       (job_valid),
    .job_i             (job_out),
    .job_pop_o         (job_pop),
    .empty             (empty),
    .pop               (pop),
    .band_index_o      (band_index_o),
    .band_height_o     (band_height_o),
    .top_row_code_o    (top_row_code_o),
    .middle_row_code_o (middle_row_code_o),
    .bottom_row_code_o (bottom_row_code_o),
    .frame_end_o       (frame_end_o)
  );

endmodule

### dv/tb_top.sv
// Self-checking testbench for the log-band bar mapper: bins in, band bars out.
`timescale 1ns / 100ps

module tb_top;
  import slbm_pkg::*;

  localparam int unsigned RANDOM_BINS   = 1500;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // One expected band bar, as it appears on the result ports
  typedef struct {
    logic [BAND_W-1:0]   band;
    logic [HEIGHT_W-1:0] height;
    logic [CODE_W-1:0]   top;
    logic [CODE_W-1:0]   mid;
    logic [CODE_W-1:0]   bot;
    logic                last;
  } band_bar_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_NOISE_FLOOR;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [MAG_W-1:0]     magnitude_i = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [BAND_W-1:0]    band_index_o;
  logic [HEIGHT_W-1:0]  band_height_o;
  logic [CODE_W-1:0]    top_row_code_o;
  logic [CODE_W-1:0]    middle_row_code_o;
  logic [CODE_W-1:0]    bottom_row_code_o;
  logic                 frame_end_o;

  spectrum_log_band_bar_mapper u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push              (push),
    .full              (full),
    .magnitude_i       (magnitude_i),
    .empty             (empty),
    .pop               (pop),
    .band_index_o      (band_index_o),
    .band_height_o     (band_height_o),
    .top_row_code_o    (top_row_code_o),
    .middle_row_code_o (middle_row_code_o),
    .bottom_row_code_o (bottom_row_code_o),
    .frame_end_o       (frame_end_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: settings, band edges and the open band of the current frame
  int unsigned nf_reg = 3;
  int unsigned gain_reg = 100;
  int unsigned fs_reg = 1024;
  int unsigned bmax_reg = 24;
  int unsigned edge_tbl [BAND_COUNT];
  int unsigned bin_idx = 0;
  int unsigned open_band = 0;
  int unsigned band_acc = 0;
  int unsigned band_bins = 0;

  band_bar_t      expected_bars [$];
  logic [MAG_W-1:0] pending_bins [$];

  bit          failed = 1'b0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  bit          bin_beat = 1'b0;
  bit          bar_beat = 1'b0;
  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned cycles = 0;

  // floor((BINS-1) * 25^n / 32^n), exact in wide integers
  function automatic int unsigned band_edge(int unsigned n);
    logic [127:0] v;
    v = BINS - 1;
    for (int unsigned t = 0; t < n; t++) v = v * 25;
    v = v >> (5 * n);
    return v[31:0];
  endfunction

  function automatic logic [CODE_W-1:0] row_char(int unsigned h, int unsigned row);
    int unsigned a;
    a = h >> 3;
    if (a == row) return (h - 8 * a) > 0 ? CODE_W'(h - 8 * a - 1) : BLANK_CODE;
    return a > row ? FULL_CODE : BLANK_CODE;
  endfunction

  // Scale a band average to a bar and split it into the three row characters
  function automatic band_bar_t scale_band(int unsigned band, int unsigned avg, bit last);
    band_bar_t   bar;
    int unsigned level;
    longint unsigned h;
    h = 0;
    if (avg > nf_reg) begin
      level = (avg - nf_reg) * gain_reg;
      if (level > fs_reg) level = fs_reg;
      if (fs_reg != 0) h = (longint'(level) * bmax_reg) / fs_reg;
    end
    h = h & 31;
    bar.band   = BAND_W'(band);
    bar.height = HEIGHT_W'(h);
    bar.top    = row_char(h, 2);
    bar.mid    = row_char(h, 1);
    bar.bot    = row_char(h, 0);
    bar.last   = last;
    return bar;
  endfunction

  // Advance the frame by one bin and queue the bar it closes, if any
  function automatic void take_bin(logic [MAG_W-1:0] mag);
    int unsigned idx;
    bit          last;
    bit          closed;
    idx = bin_idx;
    last = (idx >= BINS - 1);
    closed = 1'b0;
    if (idx >= FIRST_BIN) begin
      band_acc += mag;
      band_bins++;
      if (open_band < BAND_COUNT && idx > edge_tbl[open_band]) begin
        expected_bars.push_back(scale_band(open_band, band_acc / band_bins, last));
        open_band++;
        band_acc = 0;
        band_bins = 0;
        closed = 1'b1;
      end
    end
    if (last) begin
      if (!closed && open_band < BAND_COUNT && band_bins > 0)
        expected_bars.push_back(scale_band(open_band, band_acc / band_bins, 1'b1));
      bin_idx = 0;
      open_band = 0;
      band_acc = 0;
      band_bins = 0;
    end else begin
      bin_idx = idx + 1;
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  function automatic int unsigned draw_wait(bit on);
    return on ? $urandom_range(0, 9) : 0;
  endfunction

  // Magnitude mix: full range, low levels, and values around the noise floor
  function automatic logic [MAG_W-1:0] pick_magnitude();
    int v;
    case ($urandom_range(0, 2))
      0:       v = $urandom_range(0, 32767);
      1:       v = $urandom_range(0, 2047);
      default: v = int'(nf_reg) + $urandom_range(0, 72) - 8;
    endcase
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return MAG_W'(v);
  endfunction

  // Bin driver: hold a beat until taken, then wait out the drawn gap
  always @(negedge clk_i) begin
    if (bin_beat) push_gap = draw_wait(gaps_on);
    if (push && !bin_beat) begin
      // hold the current beat
    end else if (push_gap > 0) begin
      push <= 1'b0;
      push_gap--;
    end else if (pending_bins.size() > 0) begin
      push <= 1'b1;
      magnitude_i <= pending_bins.pop_front();
    end else begin
      push <= 1'b0;
    end
  end

  // Result sink: stall for the drawn number of cycles after each beat
  always @(negedge clk_i) begin
    if (bar_beat) pop_gap = draw_wait(stalls_on);
    if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else begin
      pop <= 1'b1;
    end
  end

  // Monitor: predict on every bin beat, check every bar beat
  always @(posedge clk_i) begin
    band_bar_t bar;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      bin_beat = rst_ni && push && !full;
      bar_beat = rst_ni && pop && !empty;
      if (bin_beat) take_bin(magnitude_i);
      if (bar_beat) begin
        if (expected_bars.size() == 0) begin
          $error("unexpected bar for band %0d", band_index_o);
          failed = 1'b1;
        end else begin
          bar = expected_bars.pop_front();
          check_field("band_index", bar.band, band_index_o);
          check_field("band_height", bar.height, band_height_o);
          check_field("top_row_code", bar.top, top_row_code_o);
          check_field("middle_row_code", bar.mid, middle_row_code_o);
          check_field("bottom_row_code", bar.bot, bottom_row_code_o);
          check_field("frame_end", bar.last, frame_end_o);
        end
      end
    end
  end

  // Register write at the falling edge; mirror the masked value in the predictor
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_NOISE_FLOOR: nf_reg = data[NF_W-1:0];
      CFG_GAIN:        gain_reg = data[GAIN_W-1:0];
      CFG_FULL_SCALE:  fs_reg = data[FS_W-1:0];
      CFG_BAR_MAX:     bmax_reg = data[BMAX_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Junk above the register width must be dropped by the block
  function automatic logic [CFG_W-1:0] with_junk(int unsigned val, int unsigned width);
    logic [CFG_W-1:0] mask;
    mask = (CFG_W'(1) << width) - 1;
    if (width >= CFG_W) mask = '1;
    return (CFG_W'($urandom) & ~mask) | (CFG_W'(val) & mask);
  endfunction

  // Wait until every bin is taken and every bar is checked, then let the back end drain
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_bins.size() != 0 || push || expected_bars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned ph;
    logic [MAG_W-1:0] directed [32] = '{
      15'd32767, 15'd32767, 15'd0, 15'd32767, 15'd3, 15'd4, 15'd1, 15'd2,
      15'd11, 15'd12, 15'd13, 15'd14, 15'd15, 15'd16, 15'd1000, 15'd32767,
      15'd0, 15'd5, 15'd32767, 15'd20, 15'd32767, 15'd0, 15'd32767, 15'd0,
      15'd7, 15'd9, 15'd32767, 15'd32767, 15'd0, 15'd1, 15'd4, 15'd32767
    };
    for (int k = 0; k < BAND_COUNT; k++) edge_tbl[k] = band_edge(BAND_COUNT - 1 - k);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // One whole frame under the reset settings: extremes, the noise floor, the last bin
    foreach (directed[k]) pending_bins.push_back(directed[k]);
    wait_idle();

    sent = 0;
    ph = 0;
    while (sent < RANDOM_BINS) begin
      case (ph)
        0: begin
          write_reg(CFG_GAIN, 16'd0);
          write_reg(CFG_NOISE_FLOOR, 16'd0);
        end
        1: begin
          write_reg(CFG_GAIN, 16'd255);
          write_reg(CFG_FULL_SCALE, 16'd0);
        end
        2: begin
          write_reg(CFG_NOISE_FLOOR, 16'd1023);
          write_reg(CFG_GAIN, 16'd255);
          write_reg(CFG_FULL_SCALE, 16'd65535);
          write_reg(CFG_BAR_MAX, 16'd31);
        end
        3: begin
          write_reg(CFG_NOISE_FLOOR, 16'd0);
          write_reg(CFG_FULL_SCALE, 16'd1);
          write_reg(CFG_BAR_MAX, 16'd0);
        end
        default: begin
          write_reg(CFG_NOISE_FLOOR, with_junk(($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, 1023) : $urandom_range(0, 64), NF_W));
          write_reg(CFG_GAIN, with_junk($urandom_range(0, 255), GAIN_W));
          write_reg(CFG_FULL_SCALE, ($urandom_range(0, 1) == 0) ?
                    CFG_W'($urandom_range(1, 65535)) : CFG_W'($urandom_range(1, 4096)));
          write_reg(CFG_BAR_MAX, with_junk($urandom_range(0, 31), BMAX_W));
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = (ph < 4) ? 32 : $urandom_range(20, 200);
      repeat (n) pending_bins.push_back(pick_magnitude());
      sent += n;
      ph++;
      wait_idle();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### spectrum_log_band_bar_mapper.f
design/slbm_pkg.sv
design/slbm_front.sv
design/slbm_job_fifo.sv
design/slbm_back.sv
design/spectrum_log_band_bar_mapper.sv
dv/tb_top.sv
